@@ rtl/szpd_pkg.sv @@
package szpd_pkg;

    localparam int LAG         = 5;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC        = 8;

    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;
    localparam int SIG_W     = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int THR_W       = 8;
    localparam int INF_W       = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_INFLUENCE = CFG_INDEX_W'(1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(56);
    localparam logic [INF_W-1:0] INF_RESET = INF_W'(128);
    localparam logic [INF_W-1:0] INF_ONE   = INF_W'(1 << FRAC);

    localparam logic [SIG_W-1:0] SIG_NONE = SIG_W'(0);
    localparam logic [SIG_W-1:0] SIG_POS  = SIG_W'(1);
    localparam logic [SIG_W-1:0] SIG_NEG  = SIG_W'(3);

    localparam int WP_W   = (LAG > 1) ? $clog2(LAG) : 1;
    localparam int FILL_W = $clog2(LAG + 1);

    localparam int VAL_W  = SAMPLE_BITS + FRAC;
    localparam int SUM_W  = VAL_W + $clog2(LAG);
    localparam int D_W    = SUM_W + 1;
    localparam int DMAG_W = D_W - 1;
    localparam int SMAG_W = SUM_W - 1;
    localparam int DSQ_W  = 2 * DMAG_W;
    localparam int LEFT_W = DSQ_W + FRAC;
    localparam int SSQ_W  = 2 * SMAG_W;
    localparam int ESQ_W  = 2 * VAL_W;
    localparam int Q_W    = ESQ_W + $clog2(LAG);
    localparam int VAR_W  = Q_W + $clog2(LAG);
    localparam int VLO_W  = VAR_W / 2;
    localparam int VHI_W  = VAR_W - VLO_W;
    localparam int THR2_W = 2 * THR_W;
    localparam int RIGHT_W = VAR_W + THR2_W;
    localparam int DIFF_W = VAL_W + 1;
    localparam int BP_W   = DIFF_W + INF_W + 1;
    localparam int BL_W   = BP_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_VAR,
        ST_MULV,
        ST_COMB,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic calc_var;
        logic mulv;
        logic comb;
        logic commit;
    } cmd_t;

endpackage

@@ rtl/szpd_ctrl.sv @@
module szpd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output szpd_pkg::cmd_t cmd
);

    szpd_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= szpd_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            szpd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = szpd_pkg::ST_MUL;
                end
            end
            szpd_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = szpd_pkg::ST_VAR;
            end
            szpd_pkg::ST_VAR: begin
                cmd.calc_var = 1'b1;
                state_next   = szpd_pkg::ST_MULV;
            end
            szpd_pkg::ST_MULV: begin
                cmd.mulv   = 1'b1;
                state_next = szpd_pkg::ST_COMB;
            end
            szpd_pkg::ST_COMB: begin
                cmd.comb   = 1'b1;
                state_next = szpd_pkg::ST_COMMIT;
            end
            szpd_pkg::ST_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = szpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = szpd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) cmd.commit |=> m_tvalid)
        else $error("result not presented after commit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("commit overwrites a pending result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer accepted while an item is in flight");

endmodule

@@ rtl/szpd_datapath.sv @@
module szpd_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  szpd_pkg::cmd_t                       cmd,
    input  logic [szpd_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 cfg_valid,
    input  logic [szpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [szpd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [szpd_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tuser
);

    localparam int VAL_W = szpd_pkg::VAL_W;
    localparam int SUM_W = szpd_pkg::SUM_W;
    localparam int D_W   = szpd_pkg::D_W;
    localparam logic signed [D_W-1:0]           LAG_D  = D_W'(szpd_pkg::LAG);
    localparam logic [szpd_pkg::VAR_W-1:0]      LAG_V  = szpd_pkg::VAR_W'(szpd_pkg::LAG);
    localparam logic [szpd_pkg::FILL_W-1:0]     LAG_F  = szpd_pkg::FILL_W'(szpd_pkg::LAG);
    localparam logic [szpd_pkg::WP_W-1:0]       WP_LAST = szpd_pkg::WP_W'(szpd_pkg::LAG - 1);
    localparam logic signed [szpd_pkg::BL_W-1:0] HALF  =
        szpd_pkg::BL_W'(1 << (szpd_pkg::FRAC - 1));

    // architectural state
    logic signed [VAL_W-1:0]            history_reg [szpd_pkg::LAG];
    logic [szpd_pkg::WP_W-1:0]          wp_reg;
    logic [szpd_pkg::FILL_W-1:0]        fill_reg;
    logic signed [VAL_W-1:0]            last_reg;
    logic signed [SUM_W-1:0]            sum_reg;
    logic [szpd_pkg::Q_W-1:0]           q_reg;
    logic [szpd_pkg::THR_W-1:0]         thr_reg;
    logic [szpd_pkg::INF_W-1:0]         inf_reg;
    logic [szpd_pkg::SIG_W-1:0]         sig_reg;
    logic                               warmed_reg;

    // item pipeline
    logic signed [VAL_W-1:0]            x8_reg;
    logic signed [D_W-1:0]              d_reg;
    logic signed [VAL_W-1:0]            old_reg;
    logic signed [szpd_pkg::DIFF_W-1:0] diff_reg;
    logic                               full_reg;
    logic [szpd_pkg::DSQ_W-1:0]         dsq_reg;
    logic [szpd_pkg::SSQ_W-1:0]         ssq_reg;
    logic [szpd_pkg::ESQ_W-1:0]         oldsq_reg;
    logic [szpd_pkg::ESQ_W-1:0]         xsq_reg;
    logic signed [szpd_pkg::BP_W-1:0]   bprod_reg;
    logic [szpd_pkg::THR2_W-1:0]        thr2_reg;
    logic [szpd_pkg::VAR_W-1:0]         var_reg;
    logic [szpd_pkg::LEFT_W-1:0]        left_reg;
    logic signed [VAL_W-1:0]            fb_reg;
    logic [szpd_pkg::Q_W-1:0]           qbase_reg;
    logic signed [SUM_W-1:0]            sumbase_reg;
    logic [szpd_pkg::VLO_W+szpd_pkg::THR2_W-1:0] plo_reg;
    logic [szpd_pkg::VHI_W+szpd_pkg::THR2_W-1:0] phi_reg;
    logic [szpd_pkg::ESQ_W-1:0]         bsq_reg;
    logic [szpd_pkg::Q_W-1:0]           qx_reg;
    logic [szpd_pkg::Q_W-1:0]           qb_reg;
    logic [szpd_pkg::RIGHT_W-1:0]       right_reg;

    logic signed [VAL_W-1:0]            x8;
    logic signed [VAL_W:0]              neg_old, neg_x8, neg_fb;
    logic [VAL_W-1:0]                   mag_old, mag_x8, mag_fb;
    logic [szpd_pkg::DMAG_W-1:0]        mag_d;
    logic [szpd_pkg::SMAG_W-1:0]        mag_s;
    logic [szpd_pkg::INF_W:0]           inf_sat;
    logic signed [szpd_pkg::BL_W-1:0]   blend_sum;
    logic                               flag;
    logic signed [VAL_W-1:0]            f;

    assign x8 = {s_tdata[szpd_pkg::SAMPLE_BITS-1:0], szpd_pkg::FRAC'(0)};

    assign neg_old = -(VAL_W+1)'(old_reg);
    assign neg_x8  = -(VAL_W+1)'(x8_reg);
    assign neg_fb  = -(VAL_W+1)'(fb_reg);
    assign mag_old = old_reg[VAL_W-1] ? neg_old[VAL_W-1:0] : old_reg;
    assign mag_x8  = x8_reg[VAL_W-1]  ? neg_x8[VAL_W-1:0]  : x8_reg;
    assign mag_fb  = fb_reg[VAL_W-1]  ? neg_fb[VAL_W-1:0]  : fb_reg;
    assign mag_d   = d_reg[D_W-1] ? szpd_pkg::DMAG_W'(-d_reg) : szpd_pkg::DMAG_W'(d_reg);
    assign mag_s   = sum_reg[SUM_W-1] ? szpd_pkg::SMAG_W'(-sum_reg)
                                      : szpd_pkg::SMAG_W'(sum_reg);
    assign inf_sat = (inf_reg > szpd_pkg::INF_ONE) ? {1'b0, szpd_pkg::INF_ONE}
                                                   : {1'b0, inf_reg};

    assign blend_sum = szpd_pkg::BL_W'({last_reg, szpd_pkg::FRAC'(0)})
                     + szpd_pkg::BL_W'(bprod_reg) + HALF;

    assign flag = full_reg && (szpd_pkg::RIGHT_W'(left_reg) > right_reg);
    assign f    = flag ? fb_reg : x8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= szpd_pkg::THR_RESET;
            inf_reg <= szpd_pkg::INF_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                szpd_pkg::CFG_THRESHOLD: thr_reg <= cfg_data[szpd_pkg::THR_W-1:0];
                szpd_pkg::CFG_INFLUENCE: inf_reg <= cfg_data[szpd_pkg::INF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x8_reg   <= x8;
            d_reg    <= D_W'(x8) * LAG_D - D_W'(sum_reg);
            old_reg  <= history_reg[wp_reg];
            diff_reg <= szpd_pkg::DIFF_W'(x8) - szpd_pkg::DIFF_W'(last_reg);
            full_reg <= (fill_reg >= LAG_F);
        end
        if (cmd.mul) begin
            dsq_reg   <= szpd_pkg::DSQ_W'(mag_d) * szpd_pkg::DSQ_W'(mag_d);
            ssq_reg   <= szpd_pkg::SSQ_W'(mag_s) * szpd_pkg::SSQ_W'(mag_s);
            oldsq_reg <= szpd_pkg::ESQ_W'(mag_old) * szpd_pkg::ESQ_W'(mag_old);
            xsq_reg   <= szpd_pkg::ESQ_W'(mag_x8) * szpd_pkg::ESQ_W'(mag_x8);
            bprod_reg <= szpd_pkg::BP_W'(diff_reg) * szpd_pkg::BP_W'($signed(inf_sat));
            thr2_reg  <= szpd_pkg::THR2_W'(thr_reg) * szpd_pkg::THR2_W'(thr_reg);
        end
        if (cmd.calc_var) begin
            var_reg     <= szpd_pkg::VAR_W'(q_reg) * LAG_V - szpd_pkg::VAR_W'(ssq_reg);
            left_reg    <= {dsq_reg, szpd_pkg::FRAC'(0)};
            fb_reg      <= blend_sum[szpd_pkg::FRAC+VAL_W-1:szpd_pkg::FRAC];
            qbase_reg   <= full_reg ? q_reg - szpd_pkg::Q_W'(oldsq_reg) : q_reg;
            sumbase_reg <= full_reg ? sum_reg - SUM_W'(old_reg) : sum_reg;
        end
        if (cmd.mulv) begin
            plo_reg <= (szpd_pkg::VLO_W+szpd_pkg::THR2_W)'(var_reg[szpd_pkg::VLO_W-1:0])
                     * (szpd_pkg::VLO_W+szpd_pkg::THR2_W)'(thr2_reg);
            phi_reg <= (szpd_pkg::VHI_W+szpd_pkg::THR2_W)'(
                           var_reg[szpd_pkg::VAR_W-1:szpd_pkg::VLO_W])
                     * (szpd_pkg::VHI_W+szpd_pkg::THR2_W)'(thr2_reg);
            bsq_reg <= szpd_pkg::ESQ_W'(mag_fb) * szpd_pkg::ESQ_W'(mag_fb);
            qx_reg  <= qbase_reg + szpd_pkg::Q_W'(xsq_reg);
        end
        if (cmd.comb) begin
            right_reg <= szpd_pkg::RIGHT_W'(plo_reg)
                       + (szpd_pkg::RIGHT_W'(phi_reg) << szpd_pkg::VLO_W);
            qb_reg    <= qbase_reg + szpd_pkg::Q_W'(bsq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < szpd_pkg::LAG; i++) begin
                history_reg[i] <= '0;
            end
            wp_reg     <= '0;
            fill_reg   <= '0;
            last_reg   <= '0;
            sum_reg    <= '0;
            q_reg      <= '0;
            sig_reg    <= szpd_pkg::SIG_NONE;
            warmed_reg <= 1'b0;
        end else if (cmd.commit) begin
            history_reg[wp_reg] <= f;
            last_reg <= f;
            sum_reg  <= sumbase_reg + SUM_W'(f);
            q_reg    <= flag ? qb_reg : qx_reg;
            wp_reg   <= (wp_reg == WP_LAST) ? '0 : wp_reg + szpd_pkg::WP_W'(1);
            if (!full_reg) begin
                fill_reg <= fill_reg + szpd_pkg::FILL_W'(1);
            end
            warmed_reg <= full_reg;
            if (!flag) begin
                sig_reg <= szpd_pkg::SIG_NONE;
            end else if (d_reg > D_W'(0)) begin
                sig_reg <= szpd_pkg::SIG_POS;
            end else begin
                sig_reg <= szpd_pkg::SIG_NEG;
            end
        end
    end

    assign m_tdata = szpd_pkg::M_TDATA_W'(sig_reg);
    assign m_tuser = warmed_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= LAG_F)
        else $error("fill count beyond window length");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg < LAG_F) |-> (szpd_pkg::FILL_W'(wp_reg) == fill_reg))
        else $error("write position out of step with fill count during warm-up");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !full_reg) |=> (sig_reg == szpd_pkg::SIG_NONE && !warmed_reg))
        else $error("signal raised during warm-up");

endmodule

@@ rtl/smoothed_zscore_peak_detector_core.sv @@
// Smoothed z-score peak detector.
// Input stream (s_*): one signed sample per transfer in s_tdata. Each sample is
// compared with the mean and standard deviation of the last LAG filtered
// samples; a deviation above threshold_q4 standard deviations gives a peak.
// Result stream (m_*): one transfer per sample, m_tdata carries the signal
// (+1, -1 or 0) and m_tuser flags that the window was full on arrival.
// Configuration (cfg_*): index 0 writes threshold_q4, index 1 influence_q8;
// other indexes are dropped. Write only while no sample is in flight.
// A new sample is taken only once the last one is committed, as the
// multiplies depend on each other: squared deviation and window sum
// squares, then variance times threshold squared, then the compare that
// selects the filtered value and updates the window. A finished result
// waits in an output register; the next sample is taken meanwhile and
// holds in its last step until the receiver takes the result.
// Reset clears the window, its sums and the fill count, and restores the
// threshold to 3.5 and the influence to 0.5; the first LAG samples only fill
// the window and report no signal.
module smoothed_zscore_peak_detector_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [szpd_pkg::S_TDATA_W-1:0]      s_tdata,   // sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [szpd_pkg::M_TDATA_W-1:0]      m_tdata,   // signal, zero fill
    output logic                                m_tuser,   // warmed
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [szpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [szpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    szpd_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    szpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    szpd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
